// ===== src/lswb_pkg.sv =====
package lswb_pkg;
  localparam logic [2:0] REQ_IDLE = 3'd0;
  localparam logic [2:0] REQ_READ = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_LR = 3'd3;
  localparam logic [2:0] REQ_SC = 3'd4;
  localparam logic [2:0] REQ_FLUSH = 3'd5;
  localparam logic [2:0] REQ_WB = 3'd6;
  localparam logic [2:0] REQ_INV = 3'd7;

  localparam logic [1:0] WID_WORD = 2'd0;
  localparam logic [1:0] WID_BYTE = 2'd1;
  localparam logic [1:0] WID_HALF = 2'd2;

  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_RSV = 2'd1;
  localparam logic [1:0] KIND_WB = 2'd2;
  localparam logic [1:0] KIND_INV = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  access_width;
    logic        sign_extend;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] mem_read_data;
    logic        mem_read_ack;
    logic        mem_write_ack;
    logic        address_cacheable;
  } req_t;

  typedef struct packed {
    logic        ack;
    logic        align_error;
    logic [31:0] read_data;
    logic        mem_read_req;
    logic [3:0]  mem_read_lanes;
    logic        mem_read_uncached;
    logic        mem_write_req;
    logic [1:0]  mem_write_kind;
    logic [31:0] mem_write_addr;
    logic [31:0] mem_write_data;
    logic [3:0]  mem_write_lanes;
    logic        mem_write_uncached;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic eval;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
  } sts_t;
endpackage

// ===== src/lswb_if.sv =====
interface lswb_req_if import lswb_pkg::*; ;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lswb_rsp_if import lswb_pkg::*; ;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/lswb_ctrl.sv =====
module lswb_ctrl import lswb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FULL = 1'b1;

  logic state_q, state_d;

  // result register may be refilled in the cycle it is taken
  assign in_ready_o = (state_q == ST_IDLE) || out_ready_i;
  assign out_valid_o = (state_q == ST_FULL);
  assign cmd_o.eval = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (sts_i.done) state_d = ST_FULL;
      ST_FULL: if (out_ready_i && !sts_i.done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== src/lswb_dp.sv =====
module lswb_dp import lswb_pkg::*; #(
  parameter int Entries = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic dcache_on_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  input  req_t req_i,
  output rsp_t rsp_o
);
  localparam int IW = $clog2(Entries);

  logic [29:0] addr_q [Entries];
  logic [31:0] data_q [Entries];
  logic [3:0]  bv_q   [Entries];
  logic        cach_q [Entries];
  logic        pend_q;

  logic [29:0] addr_d [Entries];
  logic [31:0] data_d [Entries];
  logic [3:0]  bv_d   [Entries];
  logic        cach_d [Entries];
  logic        pend_d;
  rsp_t        rsp_d;

  logic rd, wr, lrsc, fl, wb, inv;
  logic [29:0] wa;
  logic [1:0]  sh;
  logic hit_f, emp_f, ent_f, entn_f;
  logic [IW-1:0] hit, emp, ent, entn;
  logic align, ack, dc0, remove, wrt;
  logic [3:0] bsel;
  logic [31:0] wbd, r, fwd, od;
  logic [3:0] ov;
  logic [7:0] rb;
  logic [15:0] rh;

  always_comb begin
    rd = req_i.req_type == REQ_READ || req_i.req_type == REQ_LR;
    wr = req_i.req_type == REQ_WRITE || req_i.req_type == REQ_SC;
    lrsc = req_i.req_type == REQ_LR || req_i.req_type == REQ_SC;
    fl = req_i.req_type == REQ_FLUSH;
    wb = req_i.req_type == REQ_WB;
    inv = req_i.req_type == REQ_INV;
    wa = req_i.address[31:2];
    sh = req_i.address[1:0];
    hit_f = 1'b0; emp_f = 1'b0; hit = '0; emp = '0;
    for (int i = 0; i < Entries; i++) begin
      if (!hit_f && bv_q[i] != 4'd0 && addr_q[i] == wa) begin
        hit_f = 1'b1; hit = IW'(i);
      end
      if (!emp_f && bv_q[i] == 4'd0) begin
        emp_f = 1'b1; emp = IW'(i);
      end
    end
    align = 1'b0;
    case (req_i.access_width)
      WID_BYTE: begin
        bsel = 4'd1 << sh;
        wbd = {4{req_i.write_data[7:0]}};
      end
      WID_HALF: begin
        align = sh[0] && (rd || wr);
        bsel = 4'd3 << sh;
        wbd = {2{req_i.write_data[15:0]}};
      end
      default: begin
        align = (sh != 2'd0) && (rd || wr);
        bsel = 4'hf;
        wbd = req_i.write_data;
      end
    endcase
    if (wb || inv) bsel = 4'd0;

    fwd = req_i.mem_read_data;
    if (hit_f)
      for (int b = 0; b < 4; b++)
        if (bv_q[hit][b]) fwd[8*b +: 8] = data_q[hit][8*b +: 8];
    rb = fwd[8*sh +: 8];
    rh = fwd[16*sh[1] +: 16];
    case (req_i.access_width)
      WID_BYTE: r = {{24{req_i.sign_extend & rb[7]}}, rb};
      WID_HALF: r = {{16{req_i.sign_extend & rh[15]}}, rh};
      default:  r = fwd;
    endcase

    rsp_d = '0;
    ack = 1'b0;
    if (rd && !align) begin
      if (hit_f && (bsel & ~bv_q[hit]) == 4'd0) ack = 1'b1;
      else begin
        rsp_d.mem_read_req = 1'b1;
        ack = req_i.mem_read_ack;
      end
    end
    if (fl && bv_q[0] == 4'd0) ack = 1'b1;

    if (bv_q[0] == 4'd0 && (wb || inv || (lrsc && !rd))) begin
      rsp_d.mem_write_addr = req_i.address;
      rsp_d.mem_write_data = req_i.write_data;
      rsp_d.mem_write_lanes = bsel;
      rsp_d.mem_write_req = lrsc;
      rsp_d.mem_write_kind = wb ? KIND_WB : (inv ? KIND_INV : KIND_RSV);
      ack = req_i.mem_write_ack;
    end else begin
      rsp_d.mem_write_req = pend_q;
      rsp_d.mem_write_kind = lrsc ? KIND_RSV : KIND_PLAIN;
      if (pend_q) begin
        rsp_d.mem_write_addr = (lrsc && rd) ? req_i.address : {addr_q[0], 2'b00};
        rsp_d.mem_write_data = data_q[0];
        rsp_d.mem_write_lanes = bv_q[0];
        rsp_d.mem_write_uncached = !dcache_on_i || !cach_q[0];
      end else begin
        rsp_d.mem_write_addr = (lrsc && rd) ? req_i.address : 32'd0;
      end
    end

    ent_f = wr && !lrsc && (hit_f || emp_f);
    ent = hit_f ? hit : emp;
    dc0 = pend_q && ((rd && hit_f && hit == '0) || (ent_f && ent == '0));
    remove = !dc0 && (!pend_q || req_i.mem_write_ack) && !(ent_f && ent == '0);
    entn_f = ent_f;
    entn = (remove && ent_f && ent != '0) ? ent - IW'(1) : ent;
    wrt = !align && entn_f && !(!req_i.address_cacheable && entn != '0) && !dc0;
    if (wrt) ack = 1'b1;

    rsp_d.ack = ack;
    rsp_d.align_error = align;
    rsp_d.read_data = r;
    rsp_d.mem_read_lanes = bsel;
    rsp_d.mem_read_uncached = !dcache_on_i || !req_i.address_cacheable;

    ov = ent_f ? bv_q[ent] : 4'd0;
    od = (ent_f && ov != 4'd0) ? data_q[ent] : 32'd0;

    for (int i = 0; i < Entries; i++) begin
      addr_d[i] = addr_q[i]; data_d[i] = data_q[i];
      bv_d[i] = bv_q[i]; cach_d[i] = cach_q[i];
    end
    pend_d = pend_q;
    if (req_i.mem_write_ack) pend_d = 1'b0;
    if (remove) begin
      pend_d = bv_q[1] != 4'd0;
      for (int i = 0; i < Entries - 1; i++) begin
        addr_d[i] = addr_q[i+1]; data_d[i] = data_q[i+1];
        bv_d[i] = bv_q[i+1]; cach_d[i] = cach_q[i+1];
      end
      bv_d[Entries-1] = 4'd0;
    end
    if (wrt) begin
      for (int b = 0; b < 4; b++)
        if (bsel[b]) od[8*b +: 8] = wbd[8*b +: 8];
      addr_d[entn] = wa;
      data_d[entn] = od;
      bv_d[entn] = ov | bsel;
      cach_d[entn] = req_i.address_cacheable;
      if (entn == '0) pend_d = 1'b1;
    end
  end

  assign sts_o.done = cmd_i.eval;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      rsp_o <= rsp_d;
      for (int i = 0; i < Entries; i++) begin
        addr_q[i] <= addr_d[i]; data_q[i] <= data_d[i]; cach_q[i] <= cach_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      for (int i = 0; i < Entries; i++) bv_q[i] <= 4'd0;
    end else if (cmd_i.eval) begin
      pend_q <= pend_d;
      for (int i = 0; i < Entries; i++) bv_q[i] <= bv_d[i];
    end
  end
endmodule

// ===== src/load_store_write_buffer_unit.sv =====
// Load/store unit with a store buffer and load forwarding.
// Request channel req: one transaction carries the access (type, width,
// sign extend, address, store data) plus the memory read data and the
// read/write acknowledges sampled for that cycle.
// Response channel rsp: one transaction per request, carrying ack,
// align_error, formatted read data and the memory port controls.
// The response is registered: it appears in the cycle after its request is taken.
// Throughput: one request per cycle while rsp is drained; the result
// register is refilled in the same cycle it is taken. The rate is set by
// the combinational buffer search and merge over BUFFER_ENTRIES entries.
// When rsp stalls, req.ready drops and the buffer state holds.
// Reset clears all byte-valid bits, the pending write flag and dcache_on.
// dcache_on is written through cfg_we_i/cfg_wdata_i; the user must write it only while idle (not enforced).
module load_store_write_buffer_unit import lswb_pkg::*; #(
  parameter int BUFFER_ENTRIES = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  lswb_req_if.sink   req,
  lswb_rsp_if.source rsp
);
  cmd_t cmd;
  sts_t sts;
  logic dcache_on_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcache_on_q <= 1'b0;
    end else if (cfg_we_i) begin
      dcache_on_q <= cfg_wdata_i;
    end
  end

  lswb_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .cmd_o(cmd), .sts_i(sts)
  );

  lswb_dp #(.Entries(BUFFER_ENTRIES)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .dcache_on_i(dcache_on_q),
    .cmd_i(cmd), .sts_o(sts), .req_i(req.data), .rsp_o(rsp.data)
  );
endmodule

// ===== src/lswb_checker.sv =====
module lswb_checker import lswb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> rsp_valid) else $error("no response");
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid |-> req_ready) else $error("stall while empty");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> $stable(rsp_data)) else $error("payload moved");
  a_align_noack_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.align_error |-> !rsp_data.mem_read_req)
    else $error("misaligned read issued");
endmodule

bind load_store_write_buffer_unit lswb_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
